// File: sv/tsms_pkg.sv
package tsms_pkg;

    localparam int STRINGS        = 6;
    localparam int CHORDS         = 9;
    localparam int SUSTAIN_LEVELS = 5;
    localparam int MSG_DEPTH      = 12;
    localparam int DIV_STEPS      = 18;

    localparam logic [6:0] FULL_VALUE = 7'd127;

    localparam logic [1:0] ACT_CHORD  = 2'd0;
    localparam logic [1:0] ACT_STRING = 2'd1;
    localparam logic [1:0] ACT_BUTTON = 2'd2;
    localparam logic [1:0] ACT_OFF    = 2'd3;

    localparam logic [0:0] REG_THRESHOLD = 1'b0;
    localparam logic [0:0] REG_CHANNEL   = 1'b1;

    typedef enum logic [1:0] {
        MSG_OFF = 2'd0,
        MSG_ON  = 2'd1,
        MSG_AT  = 2'd2
    } msg_kind_t;

    typedef struct packed {
        msg_kind_t  kind;
        logic [6:0] note;
        logic [6:0] value;
    } msg_t;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_CHORD_STEP,
        CMD_TOUCH,
        CMD_SUS_CHECK,
        CMD_DIV_STEP,
        CMD_PRESS,
        CMD_OFF_STEP,
        CMD_BUTTON,
        CMD_DRAIN
    } cmd_op_t;

    typedef struct packed {
        cmd_op_t    op;
        logic [2:0] idx;
    } cmd_t;

    typedef struct packed {
        logic [1:0] act;
        logic       chord_ok;
        logic       string_ok;
        logic       need_div;
        logic       div_done;
        logic       have_msgs;
        logic       drain_last;
    } status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DISPATCH,
        ST_CHORD,
        ST_TOUCH,
        ST_CHECK,
        ST_DIV,
        ST_PRESS,
        ST_OFF,
        ST_DONE,
        ST_DRAIN
    } state_t;

    function automatic logic [3:0] status_hi(msg_kind_t kind);
        logic [3:0] r;
        unique case (kind)
            MSG_OFF: r = 4'h8;
            MSG_ON:  r = 4'h9;
            MSG_AT:  r = 4'hA;
            default: r = 4'h8;
        endcase
        return r;
    endfunction

    function automatic logic [10:0] sustain_len(logic [2:0] step);
        logic [10:0] r;
        unique case (step)
            3'd1:    r = 11'd500;
            3'd2:    r = 11'd1000;
            3'd3:    r = 11'd1500;
            3'd4:    r = 11'd2000;
            default: r = 11'd0;
        endcase
        return r;
    endfunction

    function automatic logic [6:0] chord_note(logic [3:0] chord, logic [2:0] s);
        logic [6:0] r;
        r = 7'd0;
        unique case ({chord, s})
            {4'd0, 3'd0}: r = 7'd40; {4'd0, 3'd1}: r = 7'd45; {4'd0, 3'd2}: r = 7'd50;
            {4'd0, 3'd3}: r = 7'd55; {4'd0, 3'd4}: r = 7'd59; {4'd0, 3'd5}: r = 7'd64;
            {4'd1, 3'd1}: r = 7'd48; {4'd1, 3'd2}: r = 7'd52;
            {4'd1, 3'd3}: r = 7'd55; {4'd1, 3'd4}: r = 7'd60; {4'd1, 3'd5}: r = 7'd64;
            {4'd2, 3'd0}: r = 7'd40; {4'd2, 3'd1}: r = 7'd47; {4'd2, 3'd2}: r = 7'd52;
            {4'd2, 3'd3}: r = 7'd55; {4'd2, 3'd4}: r = 7'd59; {4'd2, 3'd5}: r = 7'd64;
            {4'd3, 3'd0}: r = 7'd43; {4'd3, 3'd1}: r = 7'd47; {4'd3, 3'd2}: r = 7'd50;
            {4'd3, 3'd3}: r = 7'd55; {4'd3, 3'd4}: r = 7'd59; {4'd3, 3'd5}: r = 7'd67;
            {4'd4, 3'd2}: r = 7'd50;
            {4'd4, 3'd3}: r = 7'd57; {4'd4, 3'd4}: r = 7'd62; {4'd4, 3'd5}: r = 7'd65;
            {4'd5, 3'd1}: r = 7'd45; {4'd5, 3'd2}: r = 7'd52;
            {4'd5, 3'd3}: r = 7'd57; {4'd5, 3'd4}: r = 7'd60; {4'd5, 3'd5}: r = 7'd64;
            {4'd6, 3'd0}: r = 7'd43; {4'd6, 3'd1}: r = 7'd47; {4'd6, 3'd2}: r = 7'd50;
            {4'd6, 3'd3}: r = 7'd55; {4'd6, 3'd4}: r = 7'd59; {4'd6, 3'd5}: r = 7'd65;
            {4'd7, 3'd0}: r = 7'd41; {4'd7, 3'd1}: r = 7'd48; {4'd7, 3'd2}: r = 7'd53;
            {4'd7, 3'd3}: r = 7'd57; {4'd7, 3'd4}: r = 7'd60; {4'd7, 3'd5}: r = 7'd65;
            {4'd8, 3'd0}: r = 7'd40; {4'd8, 3'd1}: r = 7'd47; {4'd8, 3'd2}: r = 7'd50;
            {4'd8, 3'd3}: r = 7'd56; {4'd8, 3'd4}: r = 7'd59; {4'd8, 3'd5}: r = 7'd64;
            default: r = 7'd0;
        endcase
        return r;
    endfunction

endpackage

// File: sv/tsms_datapath.sv
module tsms_datapath
    import tsms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output status_t     status,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic [1:0]  s_action,
    input  logic [3:0]  s_chord,
    input  logic [2:0]  s_string_index,
    input  logic [15:0] s_touch_filtered,
    input  logic [15:0] s_touch_baseline,
    input  logic        s_button_down,
    input  logic [31:0] s_time_ms,
    input  logic        m_ready,
    output logic [7:0]  m_status_byte,
    output logic [6:0]  m_note,
    output logic [6:0]  m_value,
    output logic        m_last
);

    logic [15:0] thr_reg;
    logic [3:0]  chan_reg;

    logic [1:0]  act_reg;
    logic [3:0]  chord_in_reg;
    logic [2:0]  sidx_reg;
    logic [15:0] filt_reg;
    logic [15:0] base_reg;
    logic        btn_reg;
    logic [31:0] now_reg;

    logic [6:0]  note_reg  [STRINGS];
    logic        held_reg  [STRINGS];
    logic        sus_reg   [STRINGS];
    logic [31:0] stamp_reg [STRINGS];
    logic [3:0]  chord_cur_reg;
    logic [2:0]  step_reg;
    logic        btn_was_reg;

    msg_t        buf_reg [MSG_DEPTH];
    logic [3:0]  cnt_reg;
    logic [3:0]  rd_reg;

    logic [10:0] rem_reg;
    logic [17:0] dvd_reg;
    logic [17:0] q_reg;
    logic [10:0] div_reg;
    logic [4:0]  dcnt_reg;
    logic        need_div_reg;

    // per-cycle update of one string and up to two messages
    logic [2:0]  sel;
    logic        upd_en;
    logic [6:0]  upd_note;
    logic        upd_held;
    logic        upd_sus;
    logic [31:0] upd_stamp;
    logic        ea_v, eb_v;
    msg_t        ea, eb;

    logic [6:0]  cn;
    logic [6:0]  nn;
    logic        touched;
    logic [10:0] ms;
    logic [31:0] elapsed;
    logic        expired;
    logic [10:0] el11;
    logic [17:0] dvd_start;
    logic [11:0] trial;
    logic        qbit;

    assign sel       = (cmd.op == CMD_CHORD_STEP || cmd.op == CMD_OFF_STEP) ? cmd.idx : sidx_reg;
    assign cn        = chord_note(chord_cur_reg, sidx_reg);
    assign nn        = chord_note(chord_in_reg, cmd.idx);
    assign touched   = (base_reg > thr_reg) && (filt_reg < (base_reg - thr_reg));
    assign ms        = sustain_len(step_reg);
    assign elapsed   = now_reg - stamp_reg[sidx_reg];
    assign expired   = elapsed >= {21'd0, ms};
    assign el11      = elapsed[10:0];
    assign dvd_start = {el11, 7'd0} - {7'd0, el11};
    assign trial     = {rem_reg, dvd_reg[17]};
    assign qbit      = trial >= {1'b0, div_reg};

    always_comb begin
        upd_en    = 1'b0;
        upd_note  = note_reg[sel];
        upd_held  = held_reg[sel];
        upd_sus   = sus_reg[sel];
        upd_stamp = stamp_reg[sel];
        ea_v      = 1'b0;
        eb_v      = 1'b0;
        ea        = '{kind: MSG_OFF, note: note_reg[sel], value: 7'd0};
        eb        = '{kind: MSG_OFF, note: note_reg[sel], value: 7'd0};
        unique case (cmd.op)
            CMD_CHORD_STEP: begin
                if (note_reg[sel] != 7'd0 && !sus_reg[sel] && held_reg[sel]) begin
                    upd_en   = 1'b1;
                    ea_v     = 1'b1;
                    eb_v     = nn != 7'd0;
                    eb       = '{kind: MSG_ON, note: nn, value: FULL_VALUE};
                    upd_note = nn;
                end
            end
            CMD_TOUCH: begin
                upd_en = 1'b1;
                if (touched) begin
                    if (!held_reg[sel]) begin
                        if (cn != 7'd0) begin
                            ea_v     = note_reg[sel] != 7'd0;
                            eb_v     = 1'b1;
                            eb       = '{kind: MSG_ON, note: cn, value: FULL_VALUE};
                            upd_note = cn;
                        end
                        upd_held  = 1'b1;
                        upd_sus   = 1'b0;
                        upd_stamp = '0;
                    end else if (sus_reg[sel]) begin
                        ea_v = note_reg[sel] != 7'd0;
                        if (cn != 7'd0) begin
                            eb_v     = 1'b1;
                            eb       = '{kind: MSG_ON, note: cn, value: FULL_VALUE};
                            upd_note = cn;
                        end
                        upd_sus   = 1'b0;
                        upd_stamp = '0;
                    end
                end else if (held_reg[sel] && !sus_reg[sel]) begin
                    if (ms != 11'd0 && note_reg[sel] != 7'd0) begin
                        upd_sus   = 1'b1;
                        upd_stamp = now_reg;
                        ea_v      = 1'b1;
                        ea        = '{kind: MSG_AT, note: note_reg[sel], value: FULL_VALUE};
                    end else begin
                        ea_v     = note_reg[sel] != 7'd0;
                        upd_note = 7'd0;
                        upd_held = 1'b0;
                    end
                end
            end
            CMD_SUS_CHECK: begin
                if (sus_reg[sel] && ms != 11'd0 && expired) begin
                    upd_en    = 1'b1;
                    ea_v      = note_reg[sel] != 7'd0;
                    eb_v      = note_reg[sel] != 7'd0;
                    ea        = '{kind: MSG_AT, note: note_reg[sel], value: 7'd0};
                    upd_note  = 7'd0;
                    upd_held  = 1'b0;
                    upd_sus   = 1'b0;
                    upd_stamp = '0;
                end
            end
            CMD_PRESS: begin
                ea_v = 1'b1;
                ea   = '{kind: MSG_AT, note: note_reg[sel], value: FULL_VALUE - q_reg[6:0]};
            end
            CMD_OFF_STEP: begin
                upd_en    = 1'b1;
                ea_v      = note_reg[sel] != 7'd0;
                upd_note  = 7'd0;
                upd_held  = 1'b0;
                upd_sus   = 1'b0;
                upd_stamp = '0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            thr_reg  <= 16'd25;
            chan_reg <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_THRESHOLD: thr_reg  <= cfg_data;
                REG_CHANNEL:   chan_reg <= cfg_data[3:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == CMD_LOAD) begin
            act_reg      <= s_action;
            chord_in_reg <= s_chord;
            sidx_reg     <= s_string_index;
            filt_reg     <= s_touch_filtered;
            base_reg     <= s_touch_baseline;
            btn_reg      <= s_button_down;
            now_reg      <= s_time_ms;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < STRINGS; i++) begin
                note_reg[i]  <= '0;
                held_reg[i]  <= 1'b0;
                sus_reg[i]   <= 1'b0;
                stamp_reg[i] <= '0;
            end
            chord_cur_reg <= '0;
            step_reg      <= '0;
            btn_was_reg   <= 1'b0;
        end else begin
            if (upd_en) begin
                note_reg[sel]  <= upd_note;
                held_reg[sel]  <= upd_held;
                sus_reg[sel]   <= upd_sus;
                stamp_reg[sel] <= upd_stamp;
            end
            if (cmd.op == CMD_CHORD_STEP && cmd.idx == 3'(STRINGS - 1)) begin
                chord_cur_reg <= chord_in_reg;
            end
            if (cmd.op == CMD_BUTTON) begin
                if (btn_reg && !btn_was_reg) begin
                    step_reg <= (step_reg == 3'(SUSTAIN_LEVELS - 1)) ? 3'd0 : step_reg + 3'd1;
                end
                btn_was_reg <= btn_reg;
            end
        end
    end

    // message buffer: pack the present messages at the fill count
    always_ff @(posedge aclk) begin
        if (ea_v || eb_v) begin
            buf_reg[cnt_reg] <= ea_v ? ea : eb;
        end
        if (ea_v && eb_v) begin
            buf_reg[cnt_reg + 4'd1] <= eb;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else if (cmd.op == CMD_LOAD) begin
            cnt_reg <= '0;
            rd_reg  <= '0;
        end else begin
            cnt_reg <= cnt_reg + {3'd0, ea_v} + {3'd0, eb_v};
            if (cmd.op == CMD_DRAIN && m_ready) begin
                rd_reg <= rd_reg + 4'd1;
            end
        end
    end

    // restoring divider for the aftertouch pressure
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            need_div_reg <= 1'b0;
            dcnt_reg     <= '0;
        end else if (cmd.op == CMD_SUS_CHECK) begin
            need_div_reg <= sus_reg[sel] && ms != 11'd0 && !expired;
            dcnt_reg     <= 5'(DIV_STEPS);
        end else if (cmd.op == CMD_DIV_STEP) begin
            dcnt_reg <= dcnt_reg - 5'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.op == CMD_SUS_CHECK) begin
            rem_reg <= '0;
            dvd_reg <= dvd_start;
            q_reg   <= '0;
            div_reg <= ms;
        end else if (cmd.op == CMD_DIV_STEP) begin
            rem_reg <= qbit ? 11'(trial - {1'b0, div_reg}) : trial[10:0];
            dvd_reg <= {dvd_reg[16:0], 1'b0};
            q_reg   <= {q_reg[16:0], qbit};
        end
    end

    assign status.act        = act_reg;
    assign status.chord_ok   = (chord_in_reg < 4'(CHORDS)) && (chord_in_reg != chord_cur_reg);
    assign status.string_ok  = sidx_reg < 3'(STRINGS);
    assign status.need_div   = need_div_reg;
    assign status.div_done   = dcnt_reg == 5'd0;
    assign status.have_msgs  = cnt_reg != 4'd0;
    assign status.drain_last = m_ready && m_last;

    assign m_status_byte = {status_hi(buf_reg[rd_reg].kind), chan_reg};
    assign m_note        = buf_reg[rd_reg].note;
    assign m_value       = buf_reg[rd_reg].value;
    assign m_last        = rd_reg == (cnt_reg - 4'd1);

endmodule

// File: sv/tsms_ctrl.sv
module tsms_ctrl
    import tsms_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    output logic    m_valid,
    input  status_t status,
    output cmd_t    cmd
);

    state_t     state_reg, state_next;
    logic [2:0] idx_reg, idx_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            idx_reg   <= '0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        idx_next   = idx_reg;
        unique case (state_reg)
            ST_IDLE: if (s_valid) state_next = ST_DISPATCH;
            ST_DISPATCH: begin
                idx_next = '0;
                unique case (status.act)
                    ACT_CHORD:  state_next = status.chord_ok ? ST_CHORD : ST_DONE;
                    ACT_STRING: state_next = status.string_ok ? ST_TOUCH : ST_DONE;
                    ACT_BUTTON: state_next = ST_IDLE;
                    ACT_OFF:    state_next = ST_OFF;
                    default:    state_next = ST_IDLE;
                endcase
            end
            ST_CHORD, ST_OFF: begin
                idx_next = idx_reg + 3'd1;
                if (idx_reg == 3'(STRINGS - 1)) state_next = ST_DONE;
            end
            ST_TOUCH: state_next = ST_CHECK;
            ST_CHECK: state_next = ST_DIV;
            ST_DIV: begin
                if (!status.need_div) state_next = ST_DONE;
                else if (status.div_done) state_next = ST_PRESS;
            end
            ST_PRESS: state_next = ST_DONE;
            ST_DONE:  state_next = status.have_msgs ? ST_DRAIN : ST_IDLE;
            ST_DRAIN: if (status.drain_last) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready = 1'b0;
        m_valid = 1'b0;
        cmd     = '{op: CMD_NONE, idx: idx_reg};
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) cmd.op = CMD_LOAD;
            end
            ST_DISPATCH: if (status.act == ACT_BUTTON) cmd.op = CMD_BUTTON;
            ST_CHORD: cmd.op = CMD_CHORD_STEP;
            ST_OFF:   cmd.op = CMD_OFF_STEP;
            ST_TOUCH: cmd.op = CMD_TOUCH;
            ST_CHECK: cmd.op = CMD_SUS_CHECK;
            ST_DIV:   if (status.need_div && !status.div_done) cmd.op = CMD_DIV_STEP;
            ST_PRESS: cmd.op = CMD_PRESS;
            ST_DRAIN: begin
                m_valid = 1'b1;
                cmd.op  = CMD_DRAIN;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: sv/touch_string_midi_sustain.sv
// Sequence: a button sample is loaded and dispatched and gives no result beats; a
// new chord select or all-off steps through all six strings before the first beat;
// a string sample runs touch and sustain check, then, when the pressure divide runs,
// 18 quotient steps at one bit per cycle and the pressure step. Result beats then go
// out one per cycle while m_ready is high. One item is in flight at a time.
// Reset (aresetn, synchronous, active low) clears all string state, the chord,
// the sustain step, threshold to 25 and channel to 0.
module touch_string_midi_sustain
    import tsms_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [0:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [3:0]  s_chord,
    input  logic [2:0]  s_string_index,
    input  logic [15:0] s_touch_filtered,
    input  logic [15:0] s_touch_baseline,
    input  logic        s_button_down,
    input  logic [31:0] s_time_ms,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [7:0]  m_status_byte,
    output logic [6:0]  m_note,
    output logic [6:0]  m_value,
    output logic        m_last
);

    // The controller walks the strings and sequences the divide; the datapath
    // holds the per-string state, the result buffer and the divider.
    cmd_t    cmd;
    status_t status;

    tsms_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .status  (status),
        .cmd     (cmd)
    );

    // Results gather in a buffer and drain one beat per cycle while m_ready is high,
    // with last on the final beat of the item.
    tsms_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .status           (status),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .s_action         (s_action),
        .s_chord          (s_chord),
        .s_string_index   (s_string_index),
        .s_touch_filtered (s_touch_filtered),
        .s_touch_baseline (s_touch_baseline),
        .s_button_down    (s_button_down),
        .s_time_ms        (s_time_ms),
        .m_ready          (m_ready),
        .m_status_byte    (m_status_byte),
        .m_note           (m_note),
        .m_value          (m_value),
        .m_last           (m_last)
    );

endmodule

// File: sv/tsms_checker.sv
module tsms_checker (
    input logic       aclk,
    input logic       aresetn,
    input logic       s_valid,
    input logic       s_ready,
    input logic       m_valid,
    input logic       m_ready,
    input logic [7:0] m_status_byte,
    input logic [6:0] m_note,
    input logic [6:0] m_value,
    input logic       m_last
);

    // no new item taken while results drain
    assert property (@(posedge aclk) disable iff (!aresetn) !(s_ready && m_valid))
        else $error("input taken while draining");

    // the last beat closes the burst
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_ready && m_last |=> !m_valid)
        else $error("beat after last");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status_byte[7:4] == 4'h8 || m_status_byte[7:4] == 4'h9 ||
                     m_status_byte[7:4] == 4'hA))
        else $error("bad status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_note) && $stable(m_value)
                                && $stable(m_last))
        else $error("stalled beat changed");

endmodule

bind touch_string_midi_sustain tsms_checker u_chk (.*);
